// ===== hw/rtl/nps_pkg.sv =====
// nps_pkg: shared constants, codes and types of the nearest pivot search
// depends on nothing; imported by nps_sqdiff and nearest_pivot_search
package nps_pkg;

  localparam int DEF_MAX_PIVOTS = 64;
  localparam int DEF_MAX_DIMS   = 64;
  localparam int DEF_VALUE_BITS = 16;

  localparam int IDX_W      = 6;
  localparam int REG_W      = 7;
  localparam int REG_IDX_W  = 2;
  localparam int DIST_W     = 48;
  localparam int SQ_IN_W    = 24;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [63:0]       MAG_MAX  = 64'h0000_0000_00FF_FFFF;

  localparam logic [REG_IDX_W-1:0] REG_NUM_PIVOTS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS   = 2'd1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // position of an element within the scan
  typedef struct packed {
    logic first_dim;
    logic last_dim;
    logic final_elem;
  } nps_tag_t;

endpackage

// ===== hw/rtl/nps_sqdiff.sv =====
// nps_sqdiff: two-stage squared difference of a query and a pivot element
// depends on nps_pkg; instantiated by nearest_pivot_search
module nps_sqdiff
  import nps_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int PIDX_W     = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_v,
  input  nps_tag_t                     in_tag,
  input  logic [PIDX_W-1:0]            in_pidx,
  input  logic signed [VALUE_BITS-1:0] a,
  input  logic signed [VALUE_BITS-1:0] b,
  output logic                         sq_v,
  output nps_tag_t                     sq_tag,
  output logic [PIDX_W-1:0]            sq_pidx,
  output logic [DIST_W-1:0]            sq
);

  logic signed [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0]        mag;
  logic                       va_r;
  nps_tag_t                   taga_r;
  logic [PIDX_W-1:0]          pidxa_r;
  logic [VALUE_BITS:0]        maga_r;
  logic [63:0]                mag64;
  logic [SQ_IN_W-1:0]         m24;
  logic [DIST_W-1:0]          prod;
  logic                       vb_r;
  nps_tag_t                   tagb_r;
  logic [PIDX_W-1:0]          pidxb_r;
  logic [DIST_W-1:0]          sq_r;

  assign diff = (VALUE_BITS+1)'(a) - (VALUE_BITS+1)'(b);
  assign mag  = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);

  // stage a: magnitude of the difference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_v;
    end
    taga_r  <= in_tag;
    pidxa_r <= in_pidx;
    maga_r  <= mag;
  end

  assign mag64 = 64'(maga_r);
  assign m24   = SQ_IN_W'(mag64);
  assign prod  = m24 * m24;

  // stage b: square, saturated when the magnitude is out of range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    tagb_r  <= taga_r;
    pidxb_r <= pidxa_r;
    sq_r    <= (mag64 > MAG_MAX) ? DIST_MAX : prod;
  end

  assign sq_v    = vb_r;
  assign sq_tag  = tagb_r;
  assign sq_pidx = pidxb_r;
  assign sq      = sq_r;

endmodule

// ===== hw/rtl/nearest_pivot_search.sv =====
// nearest_pivot_search: top level, pivot and query memories, scan control
// depends on nps_pkg and nps_sqdiff
//
// Nearest pivot search by linear scan. Items with command 0 write one pivot
// element and items with command 1 write one query element. A query element
// marked last starts a scan over every active pivot and dimension, and the
// input stalls during the scan and while an earlier result still waits to be
// collected: the pivot memory has one read port and delivers one element a
// cycle, which then passes through a two-stage squared difference unit and a
// saturating accumulator. The result item (nearest pivot, lowest index on a
// tie, and its squared distance) sits in an output register; loads and query
// elements are taken again while it waits to be collected.
module nearest_pivot_search
  import nps_pkg::*;
#(
  parameter int MAX_PIVOTS = DEF_MAX_PIVOTS,
  parameter int MAX_DIMS   = DEF_MAX_DIMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [IDX_W-1:0]             in_pivot_index,
  input  logic [IDX_W-1:0]             in_dim_index,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [IDX_W-1:0]             out_nearest_pivot,
  output logic [DIST_W-1:0]            out_nearest_distance,
  input  logic                         cfg_we,
  input  logic [REG_IDX_W-1:0]         cfg_index,
  input  logic [REG_W-1:0]             cfg_data
);

  localparam int PIV_AW    = (MAX_PIVOTS > 1) ? $clog2(MAX_PIVOTS) : 1;
  localparam int DIM_AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PIV_DEPTH = 1 << (PIV_AW + DIM_AW);
  localparam int QRY_DEPTH = 1 << DIM_AW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [REG_W-1:0]            num_pivots_r, num_dims_r;
  logic signed [VALUE_BITS-1:0] pivot_mem [PIV_DEPTH];
  logic signed [VALUE_BITS-1:0] query_mem [QRY_DEPTH];

  logic                        in_acc;
  logic [PIV_AW-1:0]           wr_pidx;
  logic [DIM_AW-1:0]           wr_didx;
  logic                        pidx_ok, didx_ok;
  logic                        start;

  logic [31:0]                 np_cnt, nd_cnt;
  logic [PIV_AW-1:0]           np_m1_r, p_r;
  logic [DIM_AW-1:0]           nd_m1_r, d_r;
  logic                        issue_r;
  logic                        last_d, last_p;
  nps_tag_t                    issue_tag;

  logic                        v1_r;
  nps_tag_t                    tag1_r;
  logic [PIV_AW-1:0]           p1_r;
  logic signed [VALUE_BITS-1:0] q_rd_r, pv_rd_r;

  logic                        sq_v;
  nps_tag_t                    sq_tag;
  logic [PIV_AW-1:0]           sq_pidx;
  logic [DIST_W-1:0]           sq;

  logic [DIST_W-1:0]           acc_r, acc_base;
  logic [DIST_W:0]             sum_wide;
  logic [DIST_W-1:0]           sum;
  logic [DIST_W-1:0]           best_dist_r;
  logic [PIV_AW-1:0]           best_idx_r;
  logic                        take_best;

  logic                        out_load;
  logic                        out_valid_r;
  logic [IDX_W-1:0]            out_pivot_r;
  logic [DIST_W-1:0]           out_dist_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pivots_r <= REG_W'(1);
      num_dims_r   <= REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_PIVOTS: num_pivots_r <= cfg_data;
        REG_NUM_DIMS:   num_dims_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp counts to 1 .. max
  always_comb begin
    np_cnt = 32'(num_pivots_r);
    if (np_cnt == 32'd0) np_cnt = 32'd1;
    if (np_cnt > 32'(MAX_PIVOTS)) np_cnt = 32'(MAX_PIVOTS);
    nd_cnt = 32'(num_dims_r);
    if (nd_cnt == 32'd0) nd_cnt = 32'd1;
    if (nd_cnt > 32'(MAX_DIMS)) nd_cnt = 32'(MAX_DIMS);
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_pidx  = PIV_AW'(in_pivot_index);
  assign wr_didx  = DIM_AW'(in_dim_index);
  assign pidx_ok  = 32'(in_pivot_index) < 32'(MAX_PIVOTS);
  assign didx_ok  = 32'(in_dim_index) < 32'(MAX_DIMS);
  assign start    = in_acc && (in_command == CMD_QUERY) && in_last;

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (in_acc && (in_command == CMD_LOAD) && pidx_ok && didx_ok) begin
      pivot_mem[{wr_pidx, wr_didx}] <= in_value;
    end
    pv_rd_r <= pivot_mem[{p_r, d_r}];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_command == CMD_QUERY) && didx_ok) begin
      query_mem[wr_didx] <= in_value;
    end
    q_rd_r <= query_mem[d_r];
  end

  // address sequencer
  assign last_d = (d_r == nd_m1_r);
  assign last_p = (p_r == np_m1_r);
  assign issue_tag.first_dim  = (d_r == '0);
  assign issue_tag.last_dim   = last_d;
  assign issue_tag.final_elem = last_d && last_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      p_r     <= '0;
      d_r     <= '0;
    end else if (start) begin
      issue_r <= 1'b1;
      p_r     <= '0;
      d_r     <= '0;
    end else if (issue_r) begin
      if (last_d) begin
        d_r <= '0;
        if (last_p) begin
          issue_r <= 1'b0;
        end else begin
          p_r <= p_r + PIV_AW'(1);
        end
      end else begin
        d_r <= d_r + DIM_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      np_m1_r <= PIV_AW'(np_cnt - 32'd1);
      nd_m1_r <= DIM_AW'(nd_cnt - 32'd1);
    end
  end

  // tags aligned with the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= issue_r;
    end
    tag1_r <= issue_tag;
    p1_r   <= p_r;
  end

  nps_sqdiff #(
    .VALUE_BITS (VALUE_BITS),
    .PIDX_W     (PIV_AW)
  ) u_sqdiff (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (v1_r),
    .in_tag  (tag1_r),
    .in_pidx (p1_r),
    .a       (q_rd_r),
    .b       (pv_rd_r),
    .sq_v    (sq_v),
    .sq_tag  (sq_tag),
    .sq_pidx (sq_pidx),
    .sq      (sq)
  );

  // saturating accumulation and running minimum
  assign acc_base  = sq_tag.first_dim ? '0 : acc_r;
  assign sum_wide  = {1'b0, acc_base} + {1'b0, sq};
  assign sum       = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
  assign take_best = sq_v && sq_tag.last_dim && ((sq_pidx == '0) || (sum < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= DIST_MAX;
      best_idx_r  <= '0;
    end else if (take_best) begin
      best_dist_r <= sum;
      best_idx_r  <= sq_pidx;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_v) begin
      acc_r <= sum;
    end
  end

  // control
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sq_v && sq_tag.final_elem) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pivot_r <= IDX_W'(best_idx_r);
      out_dist_r  <= best_dist_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_pivot    = out_pivot_r;
  assign out_nearest_distance = out_dist_r;

endmodule
